// ===== hdl/hcb_pkg.sv =====
`timescale 1ns / 1ps
package hcb_pkg;

  localparam int unsigned CoordBits = 12;
  localparam int unsigned CountBits = 20;

  localparam logic [CoordBits-1:0] CoordMax = {CoordBits{1'b1}};
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // configuration register indexes
  typedef enum logic [2:0] {
    RegTargetHue    = 3'd0,
    RegHueTolerance = 3'd1,
    RegMinSat       = 3'd2,
    RegMinValue     = 3'd3,
    RegSampleStep   = 3'd4,
    RegMinArea      = 3'd5,
    RegFrameWidth   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  target_hue;
    logic [6:0]  hue_tolerance;
    logic [6:0]  min_saturation;
    logic [6:0]  min_value;
    logic [2:0]  sample_step;
    logic [15:0] min_area;
    logic [12:0] frame_width;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                 hit;
    logic                 eof;
    logic [CoordBits-1:0] column;
    logic [CoordBits-1:0] row;
  } cls_t;

  typedef struct packed {
    logic        found;
    logic [12:0] cx2;
    logic [12:0] cy2;
    logic [11:0] bw;
    logic [11:0] bh;
    logic [19:0] count;
  } res_t;

endpackage

// ===== hdl/hcb_front.sv =====
`timescale 1ns / 1ps
module hcb_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hcb_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  output logic              stall_o,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        red_i,
  input  logic              end_of_frame_i,
  output logic              cls_valid_o,
  input  logic              cls_stall_i,
  output hcb_pkg::cls_t     cls_o
);
  import hcb_pkg::*;

  logic                 acc;
  logic [CoordBits-1:0] col_q, col_d, row_q, row_d;
  logic [2:0]           cph_q, cph_d, rph_q, rph_d, step;
  logic                 s1_v_q, s2_v_q;
  logic                 adv;

  // stage 1 regs
  logic                 s1_samp_q, s1_eof_q;
  logic [CoordBits-1:0] s1_col_q, s1_row_q;
  logic [7:0]           mx_q, d_q;
  logic signed [17:0]   h_q;
  // stage 2 regs
  logic                 s2_hit_q, s2_eof_q;
  logic [CoordBits-1:0] s2_col_q, s2_row_q;

  assign adv     = !(s2_v_q && cls_stall_i);
  assign stall_o = !adv;
  assign acc     = valid_i && adv;
  assign step    = (cfg_i.sample_step == 3'd0) ? 3'd1 : cfg_i.sample_step;

  // raster counters
  always_comb begin
    col_d = col_q; row_d = row_q; cph_d = cph_q; rph_d = rph_q;
    if (end_of_frame_i) begin
      col_d = '0; row_d = '0; cph_d = '0; rph_d = '0;
    end else if (({1'b0, col_q} + 1'b1) >= (CoordBits+1)'(cfg_i.frame_width)
                 || col_q == CoordMax) begin
      col_d = '0; cph_d = '0;
      if (row_q != CoordMax) row_d = row_q + 1'b1;
      rph_d = ((4'(rph_q) + 4'd1) >= 4'(step)) ? 3'd0 : rph_q + 3'd1;
    end else begin
      col_d = col_q + 1'b1;
      cph_d = ((4'(cph_q) + 4'd1) >= 4'(step)) ? 3'd0 : cph_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; cph_q <= '0; rph_q <= '0;
    end else if (acc) begin
      col_q <= col_d; row_q <= row_d; cph_q <= cph_d; rph_q <= rph_d;
    end
  end

  // max, min and raw hue numerator
  logic [7:0]         mx, mn, dd;
  logic signed [17:0] h1;
  always_comb begin
    mx = red_i; mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx)  mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn)  mn = blue_i;
    dd = mx - mn;
    if (red_i == mx) begin
      h1 = 18'sd60 * ($signed({10'd0, green_i}) - $signed({10'd0, blue_i}));
      if (h1 < 0) h1 = h1 + 18'sd360 * $signed({10'd0, dd});
    end else if (green_i == mx) begin
      h1 = 18'sd60 * ($signed({10'd0, blue_i}) - $signed({10'd0, red_i}))
           + 18'sd120 * $signed({10'd0, dd});
    end else begin
      h1 = 18'sd60 * ($signed({10'd0, red_i}) - $signed({10'd0, green_i}))
           + 18'sd240 * $signed({10'd0, dd});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_samp_q <= (cph_q == 3'd0) && (rph_q == 3'd0);
      s1_eof_q  <= end_of_frame_i;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      mx_q      <= mx;
      d_q       <= dd;
      h_q       <= h1;
    end
  end

  // threshold tests by cross multiplication
  logic signed [9:0]  lo_t, hi_t;
  logic signed [20:0] lo, hi, hh;
  logic               hit;
  always_comb begin
    lo_t = $signed({2'b0, cfg_i.target_hue}) - $signed({3'b0, cfg_i.hue_tolerance});
    hi_t = $signed({2'b0, cfg_i.target_hue}) + $signed({3'b0, cfg_i.hue_tolerance});
    lo   = 21'($signed({1'b0, d_q, 1'b0}) * lo_t);
    hi   = 21'($signed({1'b0, d_q, 1'b0}) * hi_t);
    hh   = 21'(h_q);
    hit  = s1_samp_q && (d_q != 8'd0) && (hh >= lo) && (hh <= hi)
           && (15'(d_q) * 15'd100 >= 15'(cfg_i.min_saturation) * 15'(mx_q))
           && (15'(mx_q) * 15'd100 >= 15'(cfg_i.min_value) * 15'd255);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_hit_q <= hit;
      s2_eof_q <= s1_eof_q;
      s2_col_q <= s1_col_q;
      s2_row_q <= s1_row_q;
    end
  end

  assign cls_valid_o = s2_v_q;
  assign cls_o       = '{hit: s2_hit_q, eof: s2_eof_q, column: s2_col_q, row: s2_row_q};

endmodule

// ===== hdl/hcb_queue.sv =====
`timescale 1ns / 1ps
module hcb_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  hcb_pkg::cls_t data_i,
  output logic          valid_o,
  input  logic          stall_i,
  output hcb_pkg::cls_t data_o
);
  import hcb_pkg::*;

  // two-entry fifo
  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign stall_o = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign push    = valid_i && !stall_o;
  assign pop     = valid_o && !stall_i;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hdl/hcb_back.sv =====
`timescale 1ns / 1ps
module hcb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  hcb_pkg::cfg_t cfg_i,
  input  logic          valid_i,
  output logic          stall_o,
  input  hcb_pkg::cls_t cls_i,
  output logic          valid_o,
  input  logic          stall_i,
  output hcb_pkg::res_t res_o
);
  import hcb_pkg::*;

  logic [CountBits-1:0] cnt_q;
  logic [CoordBits-1:0] lc_q, gc_q, lr_q, gr_q;
  logic [CountBits-1:0] cnt_n;
  logic [CoordBits-1:0] lc_n, gc_n, lr_n, gr_n;
  logic                 acc;
  // stage a: frame totals awaiting area product
  logic                 a_v_q;
  logic [CountBits-1:0] a_cnt_q;
  logic [CoordBits-1:0] a_lc_q, a_gc_q, a_lr_q, a_gr_q;
  logic                 o_v_q;
  res_t                 o_q;
  logic                 o_free, a_free;
  logic [2:0]           step;
  logic [CountBits+5:0] area;
  logic                 found;

  assign o_free  = !o_v_q || !stall_i;
  assign a_free  = !a_v_q || o_free;
  assign stall_o = !a_free;
  assign acc     = valid_i && a_free;
  assign step    = (cfg_i.sample_step == 3'd0) ? 3'd1 : cfg_i.sample_step;

  // accumulator update with the current item
  always_comb begin
    cnt_n = cnt_q; lc_n = lc_q; gc_n = gc_q; lr_n = lr_q; gr_n = gr_q;
    if (cls_i.hit) begin
      if (cnt_q != CountMax) cnt_n = cnt_q + 1'b1;
      if (cls_i.column < lc_q) lc_n = cls_i.column;
      if (cls_i.column > gc_q) gc_n = cls_i.column;
      if (cls_i.row < lr_q)    lr_n = cls_i.row;
      if (cls_i.row > gr_q)    gr_n = cls_i.row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; lc_q <= CoordMax; gc_q <= '0; lr_q <= CoordMax; gr_q <= '0;
      a_v_q <= 1'b0;
    end else begin
      if (a_free) a_v_q <= acc && cls_i.eof;
      if (acc) begin
        if (cls_i.eof) begin
          cnt_q <= '0; lc_q <= CoordMax; gc_q <= '0; lr_q <= CoordMax; gr_q <= '0;
        end else begin
          cnt_q <= cnt_n; lc_q <= lc_n; gc_q <= gc_n; lr_q <= lr_n; gr_q <= gr_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && cls_i.eof) begin
      a_cnt_q <= cnt_n; a_lc_q <= lc_n; a_gc_q <= gc_n; a_lr_q <= lr_n; a_gr_q <= gr_n;
    end
  end

  // area test and result formatting
  assign area  = (CountBits+6)'(a_cnt_q) * (CountBits+6)'(step * step);
  assign found = area >= (CountBits+6)'(cfg_i.min_area);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else if (o_free) begin
      o_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free && a_v_q) begin
      o_q.found <= found;
      o_q.count <= 20'(a_cnt_q);
      if (found && a_cnt_q != '0) begin
        o_q.cx2 <= 13'({1'b0, a_lc_q} + {1'b0, a_gc_q});
        o_q.cy2 <= 13'({1'b0, a_lr_q} + {1'b0, a_gr_q});
        o_q.bw  <= 12'(a_gc_q - a_lc_q);
        o_q.bh  <= 12'(a_gr_q - a_lr_q);
      end else begin
        o_q.cx2 <= '0; o_q.cy2 <= '0; o_q.bw <= '0; o_q.bh <= '0;
      end
    end
  end

  assign valid_o = o_v_q;
  assign res_o   = o_q;

endmodule

// ===== hdl/hsv_color_blob_bounding_box.sv =====
`timescale 1ns / 1ps
// hsv color blob bounding box
// pixels enter on valid_i/stall_o as blue, green, red and end_of_frame in
// raster order; an item is taken when valid_i is high and stall_o is low.
// each sampled pixel is tested against hue, saturation and value limits,
// matches widen a bounding box and are counted.
// one result leaves on valid_o/stall_i for each end-of-frame pixel, carrying
// found, doubled centre, box size and match count.
// throughput: one pixel per cycle while stall_o is low, set by the two-stage
// classify pipeline. a result passes both classify stages, queue, accumulate
// stage and result register. configuration is written via cfg_we_i,
// cfg_idx_i, cfg_data_i; the user must do so only while idle (not enforced).
// reset clears counters, accumulators and sets registers to defaults. a stall
// on the result side fills the queue and then raises stall_o.
module hsv_color_blob_bounding_box (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  input  logic        end_of_frame_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        found_o,
  output logic [12:0] centre_x_doubled_o,
  output logic [12:0] centre_y_doubled_o,
  output logic [11:0] box_width_o,
  output logic [11:0] box_height_o,
  output logic [19:0] match_count_o
);
  import hcb_pkg::*;

  cfg_t cfg_q;
  logic cv, cs, qv, qs;
  cls_t cd, qd;
  res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{target_hue: 8'd0, hue_tolerance: 7'd10, min_saturation: 7'd60,
                 min_value: 7'd20, sample_step: 3'd3, min_area: 16'd100,
                 frame_width: 13'd640};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegTargetHue:    cfg_q.target_hue     <= cfg_data_i[7:0];
        RegHueTolerance: cfg_q.hue_tolerance  <= cfg_data_i[6:0];
        RegMinSat:       cfg_q.min_saturation <= cfg_data_i[6:0];
        RegMinValue:     cfg_q.min_value      <= cfg_data_i[6:0];
        RegSampleStep:   cfg_q.sample_step    <= cfg_data_i[2:0];
        RegMinArea:      cfg_q.min_area       <= cfg_data_i;
        RegFrameWidth:   cfg_q.frame_width    <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  hcb_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i, .stall_o,
    .blue_i, .green_i, .red_i, .end_of_frame_i,
    .cls_valid_o(cv), .cls_stall_i(cs), .cls_o(cd)
  );

  hcb_queue u_queue (
    .clk_i, .rst_ni, .valid_i(cv), .stall_o(cs), .data_i(cd),
    .valid_o(qv), .stall_i(qs), .data_o(qd)
  );

  hcb_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .valid_i(qv), .stall_o(qs), .cls_i(qd),
    .valid_o, .stall_i, .res_o(res)
  );

  assign found_o            = res.found;
  assign centre_x_doubled_o = res.cx2;
  assign centre_y_doubled_o = res.cy2;
  assign box_width_o        = res.bw;
  assign box_height_o       = res.bh;
  assign match_count_o      = res.count;

endmodule
